// ===== rtl/frgcd_pkg.sv =====
`default_nettype none
package frgcd_pkg;

    // Status of the shared divider as the sequencer sees it
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

// ===== rtl/frgcd_if.sv =====
`default_nettype none
// Request channel: one signed fraction
interface frgcd_in_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] numerator;
    logic signed [W-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// Result channel: one reduced fraction
interface frgcd_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] reduced_numerator;
    logic        [W-2:0] reduced_denominator;
    logic                divide_by_zero;

    modport source (output valid, output reduced_numerator, output reduced_denominator,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                    input divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/frgcd_div.sv =====
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module frgcd_div #(
    parameter int W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [W-1:0]     i_dividend,
    input  wire logic [W-1:0]     i_divisor,
    output frgcd_pkg::t_div_stat  o_stat,
    output logic      [W-1:0]     o_quotient,
    output logic      [W-1:0]     o_remainder
);
    import frgcd_pkg::*;

    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(W);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_q,    n_q;
    logic [W-1:0]  r_r,    n_r;
    logic [W-1:0]  r_d,    n_d;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {r_r, r_q[W-1]};
        diff  = trial - {1'b0, r_d};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_FULL;
            n_q    = i_dividend;
            n_r    = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                n_r = diff[W-1:0];
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_r = trial[W-1:0];
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_ONE;
            if (r_cnt == CNT_ONE) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

endmodule
`default_nettype wire

// ===== rtl/fraction_reduce_gcd_top.sv =====
`default_nettype none
// Fraction reducer: takes a signed numerator/denominator request and returns the
// fraction in lowest terms, with the sign carried on the numerator and a positive
// denominator. A zero numerator gives 0/1; a zero denominator gives 0/0 with
// divide_by_zero set. All divisions run on one restoring divider that produces
// one quotient bit per cycle. Euclid's algorithm uses it for each remainder step,
// and two more divisions by the GCD give the reduced terms. The number of Euclid
// steps is at most about 1.44 * DATA_WIDTH, worst for consecutive Fibonacci
// magnitudes; a zero denominator goes straight to the done state without the
// divider. The block holds one request at a time: i_in.ready is high only while the
// sequencer is idle. A finished result sits in an output register until taken,
// and the next request may be accepted meanwhile.
module fraction_reduce_gcd_top #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    frgcd_in_if.sink  i_in,
    frgcd_out_if.source o_out
);
    import frgcd_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] ONE = W'(1);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_GCD      = 3'd1;
    localparam logic [2:0] S_GCD_WAIT = 3'd2;
    localparam logic [2:0] S_QN_WAIT  = 3'd3;
    localparam logic [2:0] S_QD_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]   r_state;
    logic [W-1:0] r_a, r_b;        // Euclid working pair
    logic [W-1:0] r_mx, r_my;      // input magnitudes
    logic [W-1:0] r_g;             // GCD, held for the quotient divisions
    logic [W-1:0] r_qn;            // numerator magnitude over GCD
    logic         r_sign_diff;     // input signs differ
    logic         r_dbz;           // zero denominator seen
    logic         r_rem_to_a;      // remainder goes back into r_a

    logic                r_out_valid;
    logic signed [W-1:0] r_out_num;
    logic        [W-2:0] r_out_den;
    logic                r_out_dbz;

    // Divider hookup
    logic         div_start;
    logic [W-1:0] div_dividend;
    logic [W-1:0] div_divisor;
    t_div_stat    div_stat;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;

    // Request decode: magnitudes and signs
    logic         in_nx, in_ny;
    logic [W-1:0] in_mx, in_my;
    logic         out_free;
    logic         neg;

    frgcd_div #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        in_nx = i_in.numerator[W-1];
        in_ny = i_in.denominator[W-1];
        in_mx = in_nx ? (~i_in.numerator + ONE)   : i_in.numerator;
        in_my = in_ny ? (~i_in.denominator + ONE) : i_in.denominator;
    end

    // Output register can take a result when empty or being drained this cycle
    assign out_free = !r_out_valid || o_out.ready;
    // Reduced numerator is negative only when nonzero and signs differ
    assign neg = r_sign_diff && (r_qn != '0);

    // Operand select for the shared divider
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_a;
        div_divisor  = r_b;
        unique case (r_state)
            S_GCD: begin
                div_start = 1'b1;
                if (r_a != '0 && r_b != '0) begin
                    // Reduce the larger by the smaller
                    if (r_a > r_b) begin
                        div_dividend = r_a;
                        div_divisor  = r_b;
                    end else begin
                        div_dividend = r_b;
                        div_divisor  = r_a;
                    end
                end else begin
                    // One side hit zero: the other is the GCD; start mx / g
                    div_dividend = r_mx;
                    div_divisor  = r_a | r_b;
                end
            end
            S_QN_WAIT: begin
                // Chain straight into my / g once mx / g finishes
                div_start    = div_stat.done;
                div_dividend = r_my;
                div_divisor  = r_g;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Publish a finished result, or drop the held one once the sink takes it
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= (in_my == '0) ? S_DONE : S_GCD;
                    end
                end
                S_GCD: begin
                    r_state <= (r_a != '0 && r_b != '0) ? S_GCD_WAIT : S_QN_WAIT;
                end
                S_GCD_WAIT: begin
                    if (div_stat.done) begin
                        r_state <= S_GCD;
                    end
                end
                S_QN_WAIT: begin
                    if (div_stat.done) begin
                        r_state <= S_QD_WAIT;
                    end
                end
                S_QD_WAIT: begin
                    if (div_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free, then go idle
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        // Datapath registers
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_a         <= in_mx;
                    r_b         <= in_my;
                    r_mx        <= in_mx;
                    r_my        <= in_my;
                    r_sign_diff <= in_nx ^ in_ny;
                    r_dbz       <= (in_my == '0);
                end
            end
            S_GCD: begin
                r_rem_to_a <= (r_a > r_b);
                r_g        <= r_a | r_b;
            end
            S_GCD_WAIT: begin
                if (div_stat.done) begin
                    if (r_rem_to_a) begin
                        r_a <= div_rem;
                    end else begin
                        r_b <= div_rem;
                    end
                end
            end
            S_QN_WAIT: begin
                if (div_stat.done) begin
                    r_qn <= div_quo;
                end
            end
            S_QD_WAIT: begin
                // Reuse r_b for the reduced denominator
                if (div_stat.done) begin
                    r_b <= div_quo;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_dbz <= r_dbz;
                    if (r_dbz) begin
                        r_out_num <= '0;
                        r_out_den <= '0;
                    end else begin
                        r_out_num <= neg ? (~r_qn + ONE) : r_qn;
                        r_out_den <= r_b[W-2:0];
                    end
                end
            end
            default: begin
                r_rem_to_a <= r_rem_to_a;
            end
        endcase
    end

    assign i_in.ready                = (r_state == S_IDLE);
    assign o_out.valid               = r_out_valid;
    assign o_out.reduced_numerator   = r_out_num;
    assign o_out.reduced_denominator = r_out_den;
    assign o_out.divide_by_zero      = r_out_dbz;

    // The divider is never restarted while still stepping
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // No request is taken while the divider is still working on the last one
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !div_stat.busy)
        else $error("ready while divider busy");

    // A zero-denominator result carries zero terms
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divide_by_zero) |->
            (o_out.reduced_numerator == '0 && o_out.reduced_denominator == '0))
        else $error("divide-by-zero result with nonzero terms");

endmodule
`default_nettype wire

// ===== tb/sv/fraction_reduce_gcd_top_tb.sv =====
module fraction_reduce_gcd_top_tb;

    localparam int W = 32;

    // Largest positive value and the most negative value of one field
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE     = {{(W-1){1'b0}}, 1'b1};

    // End-of-run wait, receiver hold-off length and number of random requests
    localparam int DRAIN_CYCLES   = 2500;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int RANDOM_ITEMS   = 1200;

    // Kinds of random request
    typedef enum int {
        MIX_FULL,     // both fields fully random
        MIX_COMMON,   // both fields share a random common factor
        MIX_SMALL,    // small magnitudes, many repeated factors
        MIX_ZERO,     // zero numerator or zero denominator
        MIX_CORNER    // powers of two, all-ones, extremes
    } t_mix;

    typedef struct packed {
        logic [W-1:0] num;
        logic [W-1:0] den;
    } t_fraction;

    typedef struct packed {
        logic [W-1:0] rnum;
        logic [W-2:0] rden;
        logic         dbz;
    } t_lowest_terms;

    logic i_clk;
    logic i_rst_n;

    frgcd_in_if  #(.W(W)) in_if ();
    frgcd_out_if #(.W(W)) out_if ();

    fraction_reduce_gcd_top #(
        .DATA_WIDTH(W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // Requests waiting to be offered; the front stays until it is accepted
    t_fraction     fraction_q[$];
    // Reduced fractions owed by the block, oldest first
    t_lowest_terms lowest_terms_q[$];

    int unsigned accepted_cnt;
    int unsigned mismatch_cnt;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned rx_span;
    int unsigned rx_mode;
    logic        rx_holdoff;

    // Reduce num/den to lowest terms, sign on the numerator
    function automatic t_lowest_terms reduce_fraction(input logic [W-1:0] num,
                                                      input logic [W-1:0] den);
        t_lowest_terms res;
        logic          neg_n;
        logic          neg_d;
        logic [W-1:0]  mag_n;
        logic [W-1:0]  mag_d;
        logic [W-1:0]  a;
        logic [W-1:0]  b;
        logic [W-1:0]  g;
        logic [W-1:0]  quo_n;
        logic [W-1:0]  quo_d;
        neg_n = num[W-1];
        neg_d = den[W-1];
        // Magnitudes are unsigned W-bit, so the most negative value still fits
        mag_n = neg_n ? -num : num;
        mag_d = neg_d ? -den : den;
        if (mag_d == '0) begin
            res.rnum = '0;
            res.rden = '0;
            res.dbz  = 1'b1;
            return res;
        end
        a = mag_n;
        b = mag_d;
        while (a != '0 && b != '0) begin
            if (a > b) a = a % b;
            else       b = b % a;
        end
        g = (a == '0) ? b : a;
        quo_n = mag_n / g;
        quo_d = mag_d / g;
        res.rnum = (quo_n != '0 && neg_n != neg_d) ? -quo_n : quo_n;
        res.rden = quo_d[W-2:0];
        res.dbz  = 1'b0;
        return res;
    endfunction

    function automatic logic [W-1:0] pick_corner();
        logic [W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = ONE << $urandom_range(0, W-1);
            1:       v = (ONE << $urandom_range(1, W-1)) - ONE;
            2:       v = POS_MAX;
            3:       v = ONE;
            default: v = NEG_MIN;
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic t_fraction make_fraction(input t_mix kind);
        t_fraction    f;
        logic [W-1:0] g;
        case (kind)
            MIX_FULL: begin
                f.num = $urandom;
                f.den = $urandom;
            end
            MIX_COMMON: begin
                g     = $urandom_range(1, 65535);
                f.num = g * $urandom_range(0, 32767);
                f.den = g * $urandom_range(1, 32767);
                if ($urandom_range(0, 1)) f.num = -f.num;
                if ($urandom_range(0, 1)) f.den = -f.den;
            end
            MIX_SMALL: begin
                f.num = $urandom_range(0, 255);
                f.den = $urandom_range(0, 255);
                if ($urandom_range(0, 1)) f.num = -f.num;
                if ($urandom_range(0, 1)) f.den = -f.den;
            end
            MIX_ZERO: begin
                f.num = $urandom;
                f.den = $urandom;
                if ($urandom_range(0, 1)) f.num = '0;
                else                      f.den = '0;
            end
            default: begin
                f.num = pick_corner();
                f.den = pick_corner();
            end
        endcase
        return f;
    endfunction

    function automatic t_mix pick_mix();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return MIX_FULL;
        if (r < 60) return MIX_COMMON;
        if (r < 80) return MIX_SMALL;
        if (r < 90) return MIX_ZERO;
        return MIX_CORNER;
    endfunction

    task automatic push_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
        t_fraction f;
        f.num = num;
        f.den = den;
        fraction_q.push_back(f);
    endtask

    task automatic push_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            fraction_q.push_back(make_fraction(pick_mix()));
    endtask

    // Hold the sender until every request is taken and every result is back
    task automatic drain_all();
        while (fraction_q.size() != 0 || lowest_terms_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Clock: period 12
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Known values on every block input from time zero
    initial begin
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.numerator       = '0;
        in_if.denominator     = '0;
        out_if.ready          = 1'b0;
        rx_holdoff            = 1'b0;
        accepted_cnt          = 0;
        mismatch_cnt          = 0;
        burst_left            = 0;
        gap_left              = 0;
        rx_span               = 0;
        rx_mode               = 0;
    end

    // Request driver: offer the queue front in bursts with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                // Predict the result at acceptance, then advance the queue
                lowest_terms_q.push_back(reduce_fraction(fraction_q[0].num,
                                                         fraction_q[0].den));
                fraction_q.delete(0);
                accepted_cnt++;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    // Mostly short gaps, now and then one that lets the block go idle
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 700)
                                                          : $urandom_range(0, 8);
                end else begin
                    burst_left--;
                end
            end
            if (in_if.valid && !in_if.ready) begin
                // Hold the offered request until it is taken
            end else if (gap_left != 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (fraction_q.size() != 0) begin
                in_if.valid       <= 1'b1;
                in_if.numerator   <= fraction_q[0].num;
                in_if.denominator <= fraction_q[0].den;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each accepted result, stall on a pattern of its own
    always @(posedge i_clk) begin
        t_lowest_terms exp_terms;
        logic          take;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (lowest_terms_q.size() == 0) begin
                    note_mismatch($sformatf("result %0d/%0d dbz=%0b with no request pending",
                                            $signed(out_if.reduced_numerator),
                                            out_if.reduced_denominator,
                                            out_if.divide_by_zero));
                end else begin
                    exp_terms = lowest_terms_q.pop_front();
                    if (out_if.reduced_numerator !== exp_terms.rnum)
                        note_mismatch($sformatf("reduced_numerator got %0d want %0d",
                                                $signed(out_if.reduced_numerator),
                                                $signed(exp_terms.rnum)));
                    if (out_if.reduced_denominator !== exp_terms.rden)
                        note_mismatch($sformatf("reduced_denominator got %0d want %0d",
                                                out_if.reduced_denominator,
                                                exp_terms.rden));
                    if (out_if.divide_by_zero !== exp_terms.dbz)
                        note_mismatch($sformatf("divide_by_zero got %0b want %0b",
                                                out_if.divide_by_zero, exp_terms.dbz));
                end
            end
            // Switch stall pattern after a random span: open, random, sparse
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_span = $urandom_range(20, 400);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                0:       take = 1'b1;
                1:       take = $urandom_range(0, 1);
                default: take = ($urandom_range(0, 5) == 0);
            endcase
            out_if.ready <= take && !rx_holdoff;
        end
    end

    // Long receiver hold-off while requests keep coming, so the input stalls
    initial begin
        while (accepted_cnt < 300) @(posedge i_clk);
        rx_holdoff <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        rx_holdoff <= 1'b0;
    end

    // Stimulus and end of run
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero terms, signs, extremes, worst-case Euclid chain
        push_fraction(32'sd0, 32'sd5);
        push_fraction(32'sd0, -32'sd5);
        push_fraction(32'sd5, 32'sd0);
        push_fraction(32'sd0, 32'sd0);
        push_fraction(-32'sd7, 32'sd0);
        push_fraction(NEG_MIN, 32'sd0);
        push_fraction(32'sd1, 32'sd1);
        push_fraction(-32'sd1, 32'sd1);
        push_fraction(32'sd6, -32'sd4);
        push_fraction(-32'sd6, 32'sd4);
        push_fraction(-32'sd6, -32'sd4);
        push_fraction(32'sd12, 32'sd18);
        push_fraction(32'sd3, 32'sd7);
        push_fraction(POS_MAX, POS_MAX);
        push_fraction(POS_MAX, -POS_MAX);
        push_fraction(-POS_MAX, 32'sd1);
        push_fraction(32'sd1, -POS_MAX);
        push_fraction(POS_MAX, POS_MAX - ONE);
        push_fraction(32'sd1836311903, 32'sd1134903170);
        push_fraction(-32'sd1134903170, 32'sd1836311903);
        // Most negative value: magnitude still exact, results wrap to the field
        push_fraction(NEG_MIN, 32'sd1);
        push_fraction(32'sd1, NEG_MIN);
        push_fraction(NEG_MIN, NEG_MIN);
        push_fraction(NEG_MIN, 32'sd6);
        push_fraction(32'sd1 << 20, -(32'sd1 << 28));

        // Pause the sender until every directed result is back
        drain_all();

        push_random(RANDOM_ITEMS / 2);
        drain_all();
        push_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        drain_all();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && lowest_terms_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: fail the run if it never finishes
    initial begin
        #(12 * 30_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/frgcd_pkg.sv
rtl/frgcd_if.sv
rtl/frgcd_div.sv
rtl/fraction_reduce_gcd_top.sv
tb/sv/fraction_reduce_gcd_top_tb.sv
